@@ hw/rtl/eat_pkg.sv @@
// eat_pkg: shared widths, register codes and item/result structs for the
// encoder angle tracker. No dependencies; used by every file in hw/rtl.
package eat_pkg;

  localparam int ANGLE_W       = 14;
  localparam int FRAC_W        = 8;
  localparam int TABLE_ENTRIES = 64;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int OFFS_W        = 14;
  localparam int HISTORY_DEPTH = 16;
  localparam int HIST_KEEP     = HISTORY_DEPTH - 1;
  localparam int POS_W         = 48;
  localparam int TURNS_W       = 32;
  localparam int VEL_W         = 32;
  localparam int EVEL_W        = 40;
  localparam int LIN_W         = 16;
  localparam int PP_W          = 7;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 200;

  localparam int REG_IDX_W  = 2;
  localparam int REG_DATA_W = 32;

  localparam logic [REG_IDX_W-1:0] REG_POLE_PAIRS    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ELEC_ZERO     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_POS_ZERO      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_VELOCITY_GAIN = 2'd3;

  typedef struct packed {
    logic              load;
    logic [ANGLE_W-1:0] angle;
    logic [TBL_AW-1:0]  index;
    logic [OFFS_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [PP_W-1:0]       pole_pairs;
    logic [ANGLE_W-1:0]    elec_zero;
    logic [REG_DATA_W-1:0] pos_zero;
    logic [REG_DATA_W-1:0] velocity_gain;
  } cfg_t;

  typedef struct packed {
    logic [EVEL_W-1:0]  phase_rate;
    logic [VEL_W-1:0]   velocity;
    logic [POS_W-1:0]   position;
    logic [TURNS_W-1:0] turn_count;
    logic [ANGLE_W-1:0] phase_angle;
    logic [ANGLE_W-1:0] mech_angle;
    logic [LIN_W-1:0]   linear_count;
  } result_t;

endpackage

@@ hw/rtl/eat_front.sv @@
// eat_front: input side of the tracker. Takes items off the stream, decodes
// the command and holds them in a two-entry queue for the back end. Uses eat_pkg.
module eat_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [eat_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,
  output logic                           q_valid,
  input  logic                           q_pop,
  output eat_pkg::item_t                 q_item
);

  eat_pkg::item_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  eat_pkg::item_t decoded;

  // raw word keeps only its angle bits; fields packed from bit 0 up
  always_comb begin
    decoded.load  = s_tuser;
    decoded.angle = s_tdata[eat_pkg::ANGLE_W-1:0];
    decoded.index = s_tdata[21:16];
    decoded.value = s_tdata[35:22];
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (q_pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/eat_back.sv @@
// eat_back: sequencer that carries out queued items: offset table writes,
// linearisation, turn tracking, position history and velocity. Uses eat_pkg.
module eat_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  eat_pkg::item_t      q_item,
  input  eat_pkg::cfg_t       cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output eat_pkg::result_t    res
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INT  = 4'd1;
  localparam logic [3:0] ST_CNT  = 4'd2;
  localparam logic [3:0] ST_TRK  = 4'd3;
  localparam logic [3:0] ST_DIF  = 4'd4;
  localparam logic [3:0] ST_HI   = 4'd5;
  localparam logic [3:0] ST_LO   = 4'd6;
  localparam logic [3:0] ST_VEL  = 4'd7;
  localparam logic [3:0] ST_EVL  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // offset table: memory plus per-entry valid bits (unwritten reads as zero)
  logic [eat_pkg::OFFS_W-1:0]        mem [eat_pkg::TABLE_ENTRIES];
  logic [eat_pkg::TABLE_ENTRIES-1:0] tvld;
  logic [eat_pkg::OFFS_W-1:0]        lo_raw;
  logic [eat_pkg::OFFS_W-1:0]        hi_raw;
  logic                              lo_ok;
  logic                              hi_ok;
  logic [eat_pkg::TBL_AW-1:0]        idx_lo;
  logic [eat_pkg::TBL_AW-1:0]        idx_hi;

  logic [eat_pkg::ANGLE_W-1:0]       angle;
  logic signed [eat_pkg::OFFS_W-1:0] lo_off;
  logic signed [eat_pkg::OFFS_W-1:0] hi_off;
  logic signed [eat_pkg::OFFS_W:0]   diff;
  logic signed [eat_pkg::FRAC_W:0]   frac_s;
  logic signed [23:0]                prod;
  logic signed [eat_pkg::OFFS_W-1:0] lo_keep;

  logic signed [16:0]                interp;
  logic signed [16:0]                count;
  logic [eat_pkg::LIN_W-1:0]         lin;
  logic [eat_pkg::ANGLE_W-1:0]       mech;
  logic [eat_pkg::ANGLE_W-1:0]       ediff;
  logic [eat_pkg::ANGLE_W-1:0]       elec;
  logic [20:0]                       elec_prod;

  logic [eat_pkg::ANGLE_W-1:0]       prev;
  logic [eat_pkg::TURNS_W-1:0]       turns;
  logic [eat_pkg::TURNS_W-1:0]       turns_next;
  logic                              seen;
  logic signed [eat_pkg::ANGLE_W:0]  step;
  logic [eat_pkg::POS_W-1:0]         pos_next;
  logic [eat_pkg::POS_W-1:0]         pos;
  logic [eat_pkg::POS_W-1:0]         oldest;

  logic [eat_pkg::POS_W-1:0]         hist [eat_pkg::HIST_KEEP];
  logic [eat_pkg::HIST_KEEP-1:0]     hvld;

  logic [eat_pkg::POS_W:0]           dlt;
  logic                              neg;
  logic [eat_pkg::POS_W-1:0]         mag;
  logic [63:0]                       hi_p;
  logic [63:0]                       lo_p;
  logic                              sat;
  logic [34:0]                       q;
  logic [34:0]                       q_lim;
  logic [eat_pkg::VEL_W-1:0]         vel;
  logic [eat_pkg::VEL_W-1:0]         vel_next;
  logic signed [eat_pkg::EVEL_W-1:0] evel;
  logic                              out_free;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign idx_lo   = q_item.angle[eat_pkg::ANGLE_W-1:eat_pkg::FRAC_W];
  // entry 63 wraps to entry 0
  assign idx_hi   = idx_lo + {{(eat_pkg::TBL_AW-1){1'b0}}, 1'b1};
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_item.load) begin
        mem[q_item.index] <= q_item.value;
      end else begin
        lo_raw <= mem[idx_lo];
        hi_raw <= mem[idx_hi];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvld <= '0;
    end else if (q_pop && q_item.load) begin
      tvld[q_item.index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.load) begin
      lo_ok <= tvld[idx_lo];
      hi_ok <= tvld[idx_hi];
      angle <= q_item.angle;
    end
  end

  // interpolation product
  always_comb begin
    lo_off = lo_ok ? $signed(lo_raw) : '0;
    hi_off = hi_ok ? $signed(hi_raw) : '0;
    diff   = {hi_off[eat_pkg::OFFS_W-1], hi_off} - {lo_off[eat_pkg::OFFS_W-1], lo_off};
    frac_s = $signed({1'b0, angle[eat_pkg::FRAC_W-1:0]});
  end

  // floor shift of the product, then the corrected count
  always_comb begin
    interp = {{3{lo_keep[eat_pkg::OFFS_W-1]}}, lo_keep}
           + {prod[23], prod[23:8]};
    count  = $signed({3'b000, angle}) - interp;
  end

  // rollover tracking and new position
  always_comb begin
    step       = $signed({1'b0, mech}) - $signed({1'b0, prev});
    turns_next = turns;
    if (step > 15'sd8192) begin
      turns_next = turns - 32'd1;
    end else if (step < -15'sd8192) begin
      turns_next = turns + 32'd1;
    end
    if (!seen) begin
      turns_next = '0;
    end
    pos_next = {{2{turns_next[31]}}, turns_next, {eat_pkg::ANGLE_W{1'b0}}}
             + {{(eat_pkg::POS_W-eat_pkg::ANGLE_W){1'b0}}, mech}
             - {{(eat_pkg::POS_W-eat_pkg::REG_DATA_W){cfg.pos_zero[31]}}, cfg.pos_zero};
    elec_prod = {14'd0, cfg.pole_pairs} * {7'd0, ediff};
  end

  // window difference, magnitude and sign
  always_comb begin
    dlt = {pos[eat_pkg::POS_W-1], pos} - {oldest[eat_pkg::POS_W-1], oldest};
  end

  // floor scaling with saturation
  always_comb begin
    sat   = (hi_p > 64'h1_0000_0000) || (lo_p[63:16] > 48'h1_0000_0000);
    q     = {1'b0, hi_p[33:0]} + {1'b0, lo_p[49:16]}
          + {34'd0, neg && (lo_p[15:0] != 16'd0)};
    q_lim = q;
    if (neg && q > 35'h0_8000_0000) begin
      q_lim = 35'h0_8000_0000;
    end else if (!neg && q > 35'h0_7FFF_FFFF) begin
      q_lim = 35'h0_7FFF_FFFF;
    end
    if (sat) begin
      vel_next = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      vel_next = neg ? (32'd0 - q_lim[31:0]) : q_lim[31:0];
    end
    evel = $signed({{(eat_pkg::EVEL_W-eat_pkg::PP_W){1'b0}}, cfg.pole_pairs})
         * $signed({{(eat_pkg::EVEL_W-eat_pkg::VEL_W){vel[31]}}, vel});
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_INT: begin
        prod    <= 24'(diff) * 24'(frac_s);
        lo_keep <= lo_off;
      end
      ST_CNT: begin
        lin   <= count[eat_pkg::LIN_W-1:0];
        mech  <= count[eat_pkg::ANGLE_W-1:0];
        ediff <= count[eat_pkg::ANGLE_W-1:0] - cfg.elec_zero;
      end
      ST_TRK: begin
        elec   <= elec_prod[eat_pkg::ANGLE_W-1:0];
        pos    <= pos_next;
        oldest <= hvld[eat_pkg::HIST_KEEP-1] ? hist[eat_pkg::HIST_KEEP-1] : '0;
        hist[0] <= pos_next;
        for (int i = 1; i < eat_pkg::HIST_KEEP; i++) begin
          hist[i] <= hist[i-1];
        end
      end
      ST_DIF: begin
        neg <= dlt[eat_pkg::POS_W];
        mag <= dlt[eat_pkg::POS_W] ? ({eat_pkg::POS_W{1'b0}} - dlt[eat_pkg::POS_W-1:0])
                                   : dlt[eat_pkg::POS_W-1:0];
      end
      ST_HI: begin
        hi_p <= {16'd0, mag} * {48'd0, cfg.velocity_gain[31:16]};
      end
      ST_LO: begin
        lo_p <= {16'd0, mag} * {48'd0, cfg.velocity_gain[15:0]};
      end
      ST_VEL: begin
        vel <= vel_next;
      end
      default: begin
      end
    endcase
  end

  // tracker state: reset to zero turns, zero angle, empty history
  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      turns <= '0;
      seen  <= 1'b0;
      hvld  <= '0;
    end else if (state == ST_TRK) begin
      prev  <= mech;
      turns <= turns_next;
      seen  <= 1'b1;
      hvld  <= {hvld[eat_pkg::HIST_KEEP-2:0], 1'b1};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_pop && !q_item.load) begin
          state_next = ST_INT;
        end
      end
      ST_INT:  state_next = ST_CNT;
      ST_CNT:  state_next = ST_TRK;
      ST_TRK:  state_next = ST_DIF;
      ST_DIF:  state_next = ST_HI;
      ST_HI:   state_next = ST_LO;
      ST_LO:   state_next = ST_VEL;
      ST_VEL:  state_next = ST_EVL;
      ST_EVL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EVL && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVL && out_free) begin
      res.linear_count <= lin;
      res.mech_angle   <= mech;
      res.phase_angle  <= elec;
      res.turn_count   <= turns;
      res.position     <= pos;
      res.velocity     <= vel;
      res.phase_rate   <= evel;
    end
  end

endmodule

@@ hw/rtl/encoder_angle_tracker.sv @@
// Sample item: queued by the front end, then carried out by the back-end sequencer
// one at a time; it runs table read, interpolate, count, track, difference,
// two 48x16 partial products, saturate and electrical scaling in turn, and
// holds while the result is stalled. Load item: written to the table on pop.
// Reset (rst, synchronous): offset table reads as zero, history, turns and
// angle cleared, registers to defaults; no clearing pass, ready next cycle.
//
// encoder_angle_tracker: top level. Holds the configuration registers and
// joins eat_front and eat_back; uses eat_pkg.
module encoder_angle_tracker (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata from bit 0: raw_word[15:0], table_index[21:16], table_value[35:22]
  input  logic [eat_pkg::IN_DATA_W-1:0]   s_tdata,
  // s_tuser: cmd (0 sample, 1 table load)
  input  logic                            s_tuser,
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata from bit 0: linear_count[15:0], mech_angle[29:16],
  // phase_angle[43:30], turn_count[75:44], position[123:76],
  // velocity[155:124], phase_rate[195:156], zero fill above
  output logic [eat_pkg::OUT_DATA_W-1:0]  m_tdata,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [eat_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [eat_pkg::REG_DATA_W-1:0]  cfg_data
);

  eat_pkg::cfg_t    cfg;
  eat_pkg::item_t   q_item;
  eat_pkg::result_t res;
  logic             q_valid;
  logic             q_pop;

  // configuration registers; the user must write them only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pole_pairs    <= 7'd1;
      cfg.elec_zero     <= '0;
      cfg.pos_zero      <= '0;
      cfg.velocity_gain <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        eat_pkg::REG_POLE_PAIRS:    cfg.pole_pairs    <= cfg_data[eat_pkg::PP_W-1:0];
        eat_pkg::REG_ELEC_ZERO:     cfg.elec_zero     <= cfg_data[eat_pkg::ANGLE_W-1:0];
        eat_pkg::REG_POS_ZERO:      cfg.pos_zero      <= cfg_data;
        eat_pkg::REG_VELOCITY_GAIN: cfg.velocity_gain <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: accept, decode, queue
  eat_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // back: table, tracking, velocity, result register
  eat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {4'd0, res};

endmodule

@@ hw/rtl/eat_checker.sv @@
// eat_checker: port-level assertions for encoder_angle_tracker, bound to
// the top level below. Uses only the top level's ports.
module eat_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [eat_pkg::IN_DATA_W-1:0]   s_tdata,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [eat_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            cfg_we,
  input logic [eat_pkg::REG_IDX_W-1:0]   cfg_index,
  input logic [eat_pkg::REG_DATA_W-1:0]  cfg_data
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // mech angle is the low bits of the linear count
  a_mech_wrap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[29:16] == m_tdata[13:0])
    else $error("mech angle disagrees with linear count");

  // electrical velocity carries the sign of the velocity
  a_evel_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[195] == m_tdata[155]) || (m_tdata[195:156] == 40'd0))
    else $error("electrical velocity sign wrong");

endmodule

bind encoder_angle_tracker eat_checker u_eat_checker (.*);
